// ===== hw/rtl/sktif_pkg.sv =====
`timescale 1ns / 1ps
package sktif_pkg;

	localparam int KEY_W            = 32;
	localparam int PAY_W            = 64;
	localparam int DEPTH_DEF        = 32;
	localparam int PAYLOAD_BITS_DEF = 64;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_DUMP   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		RS_INSERTED  = 3'd0,
		RS_FOUND     = 3'd1,
		RS_NOT_FOUND = 3'd2,
		RS_FULL      = 3'd3,
		RS_DUMP      = 3'd4,
		RS_EMPTY     = 3'd5
	} rs_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic insert;
		logic match_cap;
		logic idx_first;
		logic idx_zero;
		logic idx_inc;
		logic out_load;
		rs_t  out_status;
		logic out_entry;
		logic out_last;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic hit;
		logic idx_last;
	} dp_stat_t;

endpackage

// ===== hw/rtl/sktif_dpath.sv =====
`timescale 1ns / 1ps
module sktif_dpath #(
	parameter int DEPTH        = sktif_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = sktif_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sktif_pkg::dp_cmd_t                ctl,
	input  logic signed [sktif_pkg::KEY_W-1:0] key,
	input  logic [sktif_pkg::PAY_W-1:0]       payload,
	output sktif_pkg::dp_stat_t               stat,
	output logic [2:0]                        status,
	output logic signed [sktif_pkg::KEY_W-1:0] out_key,
	output logic [sktif_pkg::PAY_W-1:0]       out_payload,
	output logic                              last
);
	import sktif_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	logic signed [KEY_W-1:0]    keys_q [DEPTH];
	logic [PAYLOAD_BITS-1:0]    pays_q [DEPTH];
	logic signed [KEY_W-1:0]    prev_key_w [DEPTH];
	logic [PAYLOAD_BITS-1:0]    prev_pay_w [DEPTH];
	logic [DEPTH-1:0]           ge_w;
	logic [DEPTH-1:0]           prev_ge_w;
	logic [DEPTH-1:0]           match_w;
	logic [DEPTH-1:0]           match_s1;
	logic [CNT_W-1:0]           count_q;
	logic [IDX_W-1:0]           idx_q;
	logic [IDX_W-1:0]           first_idx;
	logic [PAYLOAD_BITS-1:0]    new_pay;

	assign new_pay = payload[PAYLOAD_BITS-1:0];

	// One cell per entry. Entries below the count are sorted, so the cells whose key is
	// not less than the new key form a contiguous run at the top; that run moves up one
	// place and the new pair drops into its lowest slot, or into the first free slot if none.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam logic [CNT_W-1:0] POS = CNT_W'(g);
		logic live;

		assign live       = POS < count_q;
		assign ge_w[g]    = live && !(keys_q[g] < key);
		assign match_w[g] = live && (keys_q[g] == key);

		if (g == 0) begin : g_first
			assign prev_ge_w[g]  = 1'b0;
			assign prev_key_w[g] = key;
			assign prev_pay_w[g] = new_pay;
		end else begin : g_rest
			assign prev_ge_w[g]  = ge_w[g-1];
			assign prev_key_w[g] = keys_q[g-1];
			assign prev_pay_w[g] = pays_q[g-1];
		end

		always_ff @(posedge clk) begin
			if (ctl.insert) begin
				if (prev_ge_w[g]) begin
					keys_q[g] <= prev_key_w[g];
					pays_q[g] <= prev_pay_w[g];
				end else if (ge_w[g] || POS == count_q) begin
					keys_q[g] <= key;
					pays_q[g] <= new_pay;
				end
			end
		end
	end

	// Lowest matching slot holds the newest of equal keys.
	always_comb begin
		first_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				first_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (ctl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctl.idx_zero) begin
				idx_q <= '0;
			end else if (ctl.idx_first) begin
				idx_q <= first_idx;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.match_cap) begin
			match_s1 <= match_w;
		end
		if (ctl.out_load) begin
			status      <= ctl.out_status;
			last        <= ctl.out_last;
			out_key     <= ctl.out_entry ? keys_q[idx_q] : '0;
			out_payload <= ctl.out_entry ? PAY_W'(pays_q[idx_q]) : '0;
		end
	end

	assign stat.full     = count_q == CNT_W'(DEPTH);
	assign stat.empty    = count_q == '0;
	assign stat.hit      = |match_s1;
	assign stat.idx_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;

endmodule

// ===== hw/rtl/sktif_ctrl.sv =====
`timescale 1ns / 1ps
module sktif_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	output logic                out_valid,
	input  logic                out_stall,
	input  sktif_pkg::dp_stat_t stat,
	output sktif_pkg::dp_cmd_t  ctl
);
	import sktif_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_FIND = 4'b0010,
		S_READ = 4'b0100,
		S_DUMP = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !(state_q == S_IDLE && out_free);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(cmd))
						OP_INSERT: begin
							ctl.out_load = 1'b1;
							ctl.out_last = 1'b1;
							if (stat.full) begin
								ctl.out_status = RS_FULL;
							end else begin
								ctl.insert     = 1'b1;
								ctl.out_status = RS_INSERTED;
							end
						end
						OP_FIND: begin
							ctl.match_cap = 1'b1;
							state_d       = S_FIND;
						end
						OP_DUMP: begin
							if (stat.empty) begin
								ctl.out_load   = 1'b1;
								ctl.out_last   = 1'b1;
								ctl.out_status = RS_EMPTY;
							end else begin
								ctl.idx_zero = 1'b1;
								state_d      = S_DUMP;
							end
						end
						default: ;
					endcase
				end
			end
			S_FIND: begin
				if (stat.hit) begin
					ctl.idx_first = 1'b1;
					state_d       = S_READ;
				end else if (out_free) begin
					ctl.out_load   = 1'b1;
					ctl.out_last   = 1'b1;
					ctl.out_status = RS_NOT_FOUND;
					state_d        = S_IDLE;
				end
			end
			S_READ: begin
				if (out_free) begin
					ctl.out_load   = 1'b1;
					ctl.out_last   = 1'b1;
					ctl.out_entry  = 1'b1;
					ctl.out_status = RS_FOUND;
					state_d        = S_IDLE;
				end
			end
			S_DUMP: begin
				if (out_free) begin
					ctl.out_load   = 1'b1;
					ctl.out_entry  = 1'b1;
					ctl.out_status = RS_DUMP;
					ctl.out_last   = stat.idx_last;
					ctl.idx_inc    = 1'b1;
					if (stat.idx_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/sorted_key_table_insert_find.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Beat contents
// input     in_valid / in_stall   cmd, key, payload
// output    out_valid / out_stall status, out_key, out_payload, last
//
// Insert, a full-table insert and an empty dump load their result in the cycle that
// accepts them. A find registers its match vector; a miss then loads its result, while
// a hit first passes the priority encode into the read index. A dump of N entries emits
// N beats, one per cycle unless the output stalls, through the shared read index. Reset
// clears the entry count and the controller, not the entry storage. A new beat is taken
// only when the controller is idle and the result register is empty or being drained;
// a stalled output holds the controller in its step, but a find hit still enters S_READ.
module sorted_key_table_insert_find #(
	parameter int DEPTH        = sktif_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = sktif_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         cmd,
	input  logic signed [sktif_pkg::KEY_W-1:0] key,
	input  logic [sktif_pkg::PAY_W-1:0]        payload,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic signed [sktif_pkg::KEY_W-1:0] out_key,
	output logic [sktif_pkg::PAY_W-1:0]        out_payload,
	output logic                               last
);
	import sktif_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	sktif_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	sktif_dpath #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.key         (key),
		.payload     (payload),
		.stat        (stat),
		.status      (status),
		.out_key     (out_key),
		.out_payload (out_payload),
		.last        (last)
	);

endmodule

// ===== hw/rtl/sktif_check.sv =====
`timescale 1ns / 1ps
module sktif_check (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic [1:0]                         cmd,
	input logic signed [sktif_pkg::KEY_W-1:0] key,
	input logic [sktif_pkg::PAY_W-1:0]        payload,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [2:0]                         status,
	input logic signed [sktif_pkg::KEY_W-1:0] out_key,
	input logic [sktif_pkg::PAY_W-1:0]        out_payload,
	input logic                               last
);
	import sktif_pkg::*;

	// A held result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_key)
			&& $stable(out_payload) && $stable(last))
		else $error("result beat changed while stalled");

	// Only found and dumped entries carry a key and payload.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == RS_INSERTED || status == RS_NOT_FOUND
			|| status == RS_FULL || status == RS_EMPTY)
		|-> out_key == '0 && out_payload == '0)
		else $error("non-entry result carries data");

	// Every result except a dump entry is the sole beat of its command.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != RS_DUMP |-> last)
		else $error("single result without last");

	// A find needs the match vector before it can answer, so input stays closed.
	a_find_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == OP_FIND |=> in_stall)
		else $error("input taken while a find is pending");

endmodule

bind sorted_key_table_insert_find sktif_check u_check (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import sktif_pkg::*;

	localparam int TABLE_DEPTH = DEPTH_DEF;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam int RUN_LIMIT = 400000;
	localparam int HOLD_AT = 360;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] k;
		logic [63:0]        p;
	} table_cmd_t;

	typedef struct {
		rs_t                s;
		logic signed [31:0] k;
		logic [63:0]        p;
		logic               lst;
	} table_answer_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = 2'd0;
	logic signed [31:0] key = '0;
	logic [63:0]        payload = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] out_key;
	logic [63:0]        out_payload;
	logic               last;

	table_cmd_t         pending_cmds[$];
	table_answer_t      due_answers[$];
	logic signed [31:0] offered_keys[$];

	// Shadow copy of the table contents.
	logic signed [31:0] table_keys[TABLE_DEPTH];
	logic [63:0]        table_pays[TABLE_DEPTH];
	int                 stored = 0;

	int pushed_total = 0;
	int sent_count = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 22;
	int recv_idle_pct = 61;
	int hold_left = 0;
	bit hold_done = 1'b0;

	sorted_key_table_insert_find DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.key         (key),
		.payload     (payload),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_key     (out_key),
		.out_payload (out_payload),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic push_answer(input rs_t s, input logic signed [31:0] k,
			input logic [63:0] p, input logic lst);
		table_answer_t a;
		a.s = s;
		a.k = k;
		a.p = p;
		a.lst = lst;
		due_answers.push_back(a);
	endtask

	task automatic apply_to_table(input logic [1:0] op, input logic signed [31:0] k,
			input logic [63:0] p);
		int pos;
		int i;
		bit hit;
		pos = 0;
		hit = 1'b0;
		if (op == OP_INSERT) begin
			if (stored == TABLE_DEPTH) begin
				push_answer(RS_FULL, '0, '0, 1'b1);
			end else begin
				// Equal keys stay behind the new pair, so the newest is found first.
				while (pos < stored && table_keys[pos] < k)
					pos++;
				for (i = stored; i > pos; i--) begin
					table_keys[i] = table_keys[i - 1];
					table_pays[i] = table_pays[i - 1];
				end
				table_keys[pos] = k;
				table_pays[pos] = p;
				stored++;
				push_answer(RS_INSERTED, '0, '0, 1'b1);
			end
		end else if (op == OP_FIND) begin
			for (i = 0; i < stored && !hit; i++) begin
				if (table_keys[i] == k) begin
					hit = 1'b1;
					push_answer(RS_FOUND, table_keys[i], table_pays[i], 1'b1);
				end
			end
			if (!hit)
				push_answer(RS_NOT_FOUND, '0, '0, 1'b1);
		end else if (op == OP_DUMP) begin
			if (stored == 0)
				push_answer(RS_EMPTY, '0, '0, 1'b1);
			for (i = 0; i < stored; i++)
				push_answer(RS_DUMP, table_keys[i], table_pays[i], i == stored - 1);
		end
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : cmd_driver
		table_cmd_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= OP_INSERT;
			key <= '0;
			payload <= '0;
			sent_count <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_to_table(cmd, key, payload);
				sent_count <= sent_count + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_cmds.pop_front();
					in_valid <= 1'b1;
					cmd <= nxt.op;
					key <= nxt.k;
					payload <= nxt.p;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		table_answer_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_answers.size() == 0) begin
					$display("%0t ns: unexpected beat: status %0d key %h payload %h last %0d",
						$time, status, out_key, out_payload, last);
					mismatches++;
				end else begin
					want = due_answers.pop_front();
					check_field("status", 64'(want.s), 64'(status));
					check_field("out_key", 64'(want.k), 64'(out_key));
					check_field("out_payload", want.p, out_payload);
					check_field("last", 64'(want.lst), 64'(last));
				end
			end
			// One long hold-off lets the block back up into its input.
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!hold_done && sent_count == HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_cmd(input logic [1:0] op, input logic signed [31:0] k,
			input logic [63:0] p);
		table_cmd_t c;
		c.op = op;
		c.k = k;
		c.p = p;
		pending_cmds.push_back(c);
		pushed_total++;
		if (op == OP_INSERT)
			offered_keys.push_back(k);
	endtask

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(9))
			0, 1, 2, 3: return int'($urandom_range(8)) - 4;
			4: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] pick_payload();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic wait_drained();
		while (sent_count != pushed_total || due_answers.size() != 0)
			@(posedge clk);
	endtask

	// Each phase starts only once the previous one has fully answered.
	task automatic run_phase(input int send_pct, input int recv_pct, input int n);
		int r;
		logic signed [31:0] k;
		wait_drained();
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 14) begin
				queue_cmd(OP_INSERT, pick_key(), pick_payload());
			end else if (r < 84) begin
				if (offered_keys.size() != 0 && $urandom_range(9) < 6)
					k = offered_keys[$urandom_range(offered_keys.size() - 1)];
				else
					k = pick_key();
				queue_cmd(OP_FIND, k, {$urandom, $urandom});
			end else if (r < 94) begin
				queue_cmd(OP_DUMP, $urandom, {$urandom, $urandom});
			end else begin
				queue_cmd(OP_UNKNOWN, $urandom, {$urandom, $urandom});
			end
		end
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_cmd(OP_DUMP, 32'sd0, '0);
		queue_cmd(OP_FIND, 32'sd0, '0);
		queue_cmd(OP_INSERT, 32'sh8000_0000, '1);
		queue_cmd(OP_INSERT, 32'sh7fff_ffff, '0);
		queue_cmd(OP_INSERT, 32'sd5, 64'h0123_4567_89ab_cdef);
		queue_cmd(OP_INSERT, 32'sd5, 64'hfedc_ba98_7654_3210);
		queue_cmd(OP_INSERT, -32'sd1, {$urandom, $urandom});
		queue_cmd(OP_INSERT, 32'sd0, {$urandom, $urandom});
		queue_cmd(OP_FIND, 32'sd5, '0);
		queue_cmd(OP_FIND, 32'sh8000_0000, '0);
		queue_cmd(OP_FIND, 32'sh7fff_ffff, '1);
		queue_cmd(OP_FIND, 32'sd6, '0);
		queue_cmd(OP_FIND, -32'sd1, '0);
		queue_cmd(OP_UNKNOWN, $urandom, {$urandom, $urandom});
		queue_cmd(OP_DUMP, 32'sd0, '0);
		queue_cmd(OP_INSERT, 32'sd5, 64'h5555_aaaa_5555_aaaa);
		queue_cmd(OP_FIND, 32'sd5, '0);
		queue_cmd(OP_DUMP, 32'sd0, '0);

		run_phase(22, 61, 150);
		run_phase(61, 22, 150);
		run_phase(0, 0, 150);

		wait_drained();
		// A command that answers nothing leaves the block idle; the wait gives any stray beat time to show.
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/sktif_pkg.sv
hw/rtl/sktif_dpath.sv
hw/rtl/sktif_ctrl.sv
hw/rtl/sorted_key_table_insert_find.sv
hw/rtl/sktif_check.sv
dv/testbench.sv
